// ===== src/gdqs_pkg.sv =====
// Shared types and constants of the gaze dwell quadrant selector.
package gdqs_pkg;

    localparam int TIME_W      = 32;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int REGION_W    = 3;
    localparam int PROG_W      = 9;
    localparam int QUOT_W      = 8;
    localparam int GAIN_W      = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_GAIN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_H_DEAD_BAND    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_V_DEAD_BAND    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DWELL_TIME     = 2'd3;

    localparam logic [CFG_DATA_W-1:0] GAIN_RESET      = 16'd7864;
    localparam logic [CFG_DATA_W-1:0] DEAD_BAND_RESET = 16'd5243;
    localparam logic [CFG_DATA_W-1:0] DWELL_RESET     = 16'd400;

    localparam logic [REGION_W-1:0] REGION_CENTRE      = 3'd0;
    localparam logic [REGION_W-1:0] REGION_UPPER_LEFT  = 3'd1;
    localparam logic [REGION_W-1:0] REGION_UPPER_RIGHT = 3'd2;
    localparam logic [REGION_W-1:0] REGION_LOWER_LEFT  = 3'd3;
    localparam logic [REGION_W-1:0] REGION_LOWER_RIGHT = 3'd4;

    localparam logic [PROG_W-1:0] PROGRESS_FULL = 9'd256;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_result_t;

endpackage

// ===== src/gdqs_if.sv =====
// Handshake channels for gaze samples and selector results.
interface gdqs_sample_if #(
    parameter int COORD_BITS = 16
);
    import gdqs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] gaze_x;
    logic [COORD_BITS-1:0] gaze_y;
    logic                  sample_valid;
    logic [TIME_W-1:0]     time_ms;

    modport source (output valid, gaze_x, gaze_y, sample_valid, time_ms, input ready);
    modport sink   (input valid, gaze_x, gaze_y, sample_valid, time_ms, output ready);
endinterface

interface gdqs_result_if #(
    parameter int COORD_BITS = 16
);
    import gdqs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  gaze_ok;
    logic [COORD_BITS-1:0] smoothed_x;
    logic [COORD_BITS-1:0] smoothed_y;
    logic [REGION_W-1:0]   candidate_region;
    logic [REGION_W-1:0]   active_region;
    logic [PROG_W-1:0]     dwell_progress;

    modport source (output valid, gaze_ok, smoothed_x, smoothed_y, candidate_region,
                    active_region, dwell_progress, input ready);
    modport sink   (input valid, gaze_ok, smoothed_x, smoothed_y, candidate_region,
                    active_region, dwell_progress, output ready);
endinterface

// ===== src/gdqs_lowpass.sv =====
// Shared low-pass filter unit: registered gain product, then rounding, add and clamp.
module gdqs_lowpass #(
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic [gdqs_pkg::GAIN_W-1:0]   gain,
    input  logic [COORD_BITS-1:0]         sample,
    input  logic [COORD_BITS-1:0]         current,
    output logic [COORD_BITS-1:0]         filtered
);
    import gdqs_pkg::*;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int SUM_W  = COORD_BITS + 3;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   biased;
    logic signed [PROD_W-1:0]   shifted;
    logic signed [SUM_W-1:0]    sum;

    assign diff      = $signed({1'b0, sample}) - $signed({1'b0, current});
    assign gain_s    = $signed({1'b0, gain});
    assign prod_next = PROD_W'(diff) * PROD_W'(gain_s);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // Round half up, then an arithmetic shift gives the floor.
    assign biased  = prod_reg + PROD_W'(32768);
    assign shifted = biased >>> GAIN_W;
    assign sum     = $signed({3'b000, current}) + SUM_W'(shifted);

    always_comb
    begin
        if (sum[SUM_W-1])
        begin
            filtered = '0;
        end
        else if (sum[SUM_W-2:COORD_BITS] != '0)
        begin
            filtered = '1;
        end
        else
        begin
            filtered = sum[COORD_BITS-1:0];
        end
    end

endmodule

// ===== src/gdqs_divider.sv =====
// Restoring divider that yields eight quotient bits, one per cycle.
module gdqs_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [gdqs_pkg::CFG_DATA_W-1:0]  dividend,
    input  logic [gdqs_pkg::CFG_DATA_W-1:0]  divisor,
    output gdqs_pkg::div_result_t            result
);
    import gdqs_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  done_reg;
    logic                  done_next;
    logic [CFG_DATA_W-1:0] rem_reg;
    logic [CFG_DATA_W-1:0] rem_next;
    logic [CFG_DATA_W-1:0] div_reg;
    logic [QUOT_W-1:0]     quot_reg;
    logic [QUOT_W-1:0]     quot_next;
    logic [CFG_DATA_W:0]   rem_shift;
    logic [CFG_DATA_W:0]   rem_diff;

    // The remainder always stays below the divisor, so doubling it fits in one extra bit.
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, div_reg};

    always_comb
    begin
        count_next = count_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        done_next  = 1'b0;
        if (start)
        begin
            count_next = CNT_W'(QUOT_W);
            rem_next   = dividend;
            quot_next  = '0;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - CNT_W'(1);
            done_next  = (count_reg == CNT_W'(1));
            if (!rem_diff[CFG_DATA_W])
            begin
                rem_next  = rem_diff[CFG_DATA_W-1:0];
                quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[CFG_DATA_W-1:0];
                quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign result.done     = done_reg;
    assign result.quotient = quot_reg;

endmodule

// ===== src/gaze_dwell_quadrant_selector.sv =====
// Top level: sequencer, configuration registers, region tracking and output register.
// A sample is taken when the block is idle. An invalid sample goes straight to the done
// state; a valid one is filtered on both axes and classified, and the eight-step progress
// divider runs when needed. The result waits in the done state until the output register is free.
// The next sample is taken the cycle after the result is loaded, while it waits in that register.
// Reset (asynchronous, active low) restores default registers, centres the filter at half.
module gaze_dwell_quadrant_selector #(
    parameter int COORD_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    gdqs_sample_if.sink                       samples,
    gdqs_result_if.source                     results,
    input  logic                              cfg_en,
    input  logic [gdqs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gdqs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gdqs_pkg::*;

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE  = 3'd0;
    localparam logic [STATE_W-1:0] S_MULX  = 3'd1;
    localparam logic [STATE_W-1:0] S_ADDX  = 3'd2;
    localparam logic [STATE_W-1:0] S_MULY  = 3'd3;
    localparam logic [STATE_W-1:0] S_ADDY  = 3'd4;
    localparam logic [STATE_W-1:0] S_CLASS = 3'd5;
    localparam logic [STATE_W-1:0] S_DIV   = 3'd6;
    localparam logic [STATE_W-1:0] S_DONE  = 3'd7;

    localparam int CMP_W = (COORD_BITS > CFG_DATA_W ? COORD_BITS : CFG_DATA_W) + 1;
    localparam logic [COORD_BITS-1:0] HALF = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Configuration
    logic [CFG_DATA_W-1:0] gain_reg;
    logic [CFG_DATA_W-1:0] hband_reg;
    logic [CFG_DATA_W-1:0] vband_reg;
    logic [CFG_DATA_W-1:0] dwell_reg;

    // Sequencer and block state
    logic [STATE_W-1:0]    state_reg, state_next;
    logic [COORD_BITS-1:0] fx_reg, fx_next;
    logic [COORD_BITS-1:0] fy_reg, fy_next;
    logic [REGION_W-1:0]   held_reg, held_next;
    logic [TIME_W-1:0]     start_reg, start_next;
    logic [PROG_W-1:0]     prog_reg, prog_next;
    logic [REGION_W-1:0]   active_reg, active_next;

    // Latched sample
    logic [COORD_BITS-1:0] gx_reg, gy_reg;
    logic                  ok_reg;
    logic [TIME_W-1:0]     t_reg;

    // Output register
    logic                  ovalid_reg, ovalid_next;
    logic                  o_ok_reg;
    logic [COORD_BITS-1:0] o_x_reg, o_y_reg;
    logic [REGION_W-1:0]   o_cand_reg, o_act_reg;
    logic [PROG_W-1:0]     o_prog_reg;
    logic                  out_load;

    logic                  accept;
    logic                  axis_y;
    logic                  mul_load;
    logic [COORD_BITS-1:0] lp_sample, lp_current, lp_out;
    logic                  div_start;
    div_result_t           div_res;
    logic [CFG_DATA_W-1:0] dwell_eff;
    logic [TIME_W-1:0]     elapsed;
    logic                  dwell_met;

    logic [COORD_BITS-1:0] mag_x, mag_y;
    logic                  in_band;
    logic [REGION_W-1:0]   region;

    assign accept          = samples.valid && samples.ready;
    assign samples.ready   = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            hband_reg <= DEAD_BAND_RESET;
            vband_reg <= DEAD_BAND_RESET;
            dwell_reg <= DWELL_RESET;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                REG_SMOOTHING_GAIN: gain_reg  <= cfg_data;
                REG_H_DEAD_BAND:    hband_reg <= cfg_data;
                REG_V_DEAD_BAND:    vband_reg <= cfg_data;
                REG_DWELL_TIME:     dwell_reg <= cfg_data;
                default:            gain_reg  <= gain_reg;
            endcase
        end
    end

    // One filter unit serves both axes in turn.
    assign axis_y     = (state_reg == S_MULY) || (state_reg == S_ADDY);
    assign mul_load   = (state_reg == S_MULX) || (state_reg == S_MULY);
    assign lp_sample  = axis_y ? gy_reg : gx_reg;
    assign lp_current = axis_y ? fy_reg : fx_reg;

    gdqs_lowpass #(
        .COORD_BITS (COORD_BITS)
    ) u_lowpass (
        .clk      (clk),
        .load     (mul_load),
        .gain     (gain_reg),
        .sample   (lp_sample),
        .current  (lp_current),
        .filtered (lp_out)
    );

    assign dwell_eff = (dwell_reg == '0) ? CFG_DATA_W'(1) : dwell_reg;
    assign elapsed   = t_reg - start_reg;
    assign dwell_met = (elapsed >= TIME_W'(dwell_eff));

    gdqs_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed[CFG_DATA_W-1:0]),
        .divisor  (dwell_eff),
        .result   (div_res)
    );

    // Quadrant classification of the freshly filtered point.
    assign mag_x   = fx_reg[COORD_BITS-1] ? (fx_reg - HALF) : (HALF - fx_reg);
    assign mag_y   = fy_reg[COORD_BITS-1] ? (fy_reg - HALF) : (HALF - fy_reg);
    assign in_band = (CMP_W'(mag_x) < CMP_W'(hband_reg)) || (CMP_W'(mag_y) < CMP_W'(vband_reg));

    always_comb
    begin
        priority if (in_band)
        begin
            region = REGION_CENTRE;
        end
        else if (!fy_reg[COORD_BITS-1])
        begin
            region = fx_reg[COORD_BITS-1] ? REGION_UPPER_RIGHT : REGION_UPPER_LEFT;
        end
        else
        begin
            region = fx_reg[COORD_BITS-1] ? REGION_LOWER_RIGHT : REGION_LOWER_LEFT;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        fx_next     = fx_reg;
        fy_next     = fy_reg;
        held_next   = held_reg;
        start_next  = start_reg;
        prog_next   = prog_reg;
        active_next = active_reg;
        div_start   = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    active_next = REGION_CENTRE;
                    state_next  = samples.sample_valid ? S_MULX : S_DONE;
                end
            end
            S_MULX:  state_next = S_ADDX;
            S_ADDX:
            begin
                fx_next    = lp_out;
                state_next = S_MULY;
            end
            S_MULY:  state_next = S_ADDY;
            S_ADDY:
            begin
                fy_next    = lp_out;
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                state_next = S_DONE;
                if (region != held_reg)
                begin
                    held_next  = region;
                    start_next = t_reg;
                    prog_next  = '0;
                end
                else if (held_reg == REGION_CENTRE)
                begin
                    prog_next = '0;
                end
                else if (dwell_met)
                begin
                    prog_next   = PROGRESS_FULL;
                    active_next = held_reg;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    prog_next  = {1'b0, div_res.quotient};
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold the finished result until the output register is free.
                if (!ovalid_reg || results.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (out_load)
        begin
            ovalid_next = 1'b1;
        end
        else if (results.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fx_reg     <= HALF;
            fy_reg     <= HALF;
            held_reg   <= REGION_CENTRE;
            start_reg  <= '0;
            prog_reg   <= '0;
            active_reg <= REGION_CENTRE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fx_reg     <= fx_next;
            fy_reg     <= fy_next;
            held_reg   <= held_next;
            start_reg  <= start_next;
            prog_reg   <= prog_next;
            active_reg <= active_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gx_reg <= samples.gaze_x;
            gy_reg <= samples.gaze_y;
            ok_reg <= samples.sample_valid;
            t_reg  <= samples.time_ms;
        end
        if (out_load)
        begin
            o_ok_reg   <= ok_reg;
            o_x_reg    <= fx_reg;
            o_y_reg    <= fy_reg;
            o_cand_reg <= held_reg;
            o_act_reg  <= active_reg;
            o_prog_reg <= prog_reg;
        end
    end

    assign results.valid            = ovalid_reg;
    assign results.gaze_ok          = o_ok_reg;
    assign results.smoothed_x       = o_x_reg;
    assign results.smoothed_y       = o_y_reg;
    assign results.candidate_region = o_cand_reg;
    assign results.active_region    = o_act_reg;
    assign results.dwell_progress   = o_prog_reg;

endmodule
